// ===== rtl/core/icfp_pkg.sv =====
package icfp_pkg;

    localparam int DATA_W      = 32;
    localparam int GAIN_W      = 31;
    localparam int POS_SLOT_W  = 16;
    localparam int AUX_SLOT_W  = 12;
    localparam int CFG_INDEX_W = 3;

    typedef logic signed [DATA_W-1:0] value_t;
    typedef logic signed [DATA_W:0]   value_ext_t;
    typedef logic [GAIN_W-1:0]        gain_t;
    typedef logic [POS_SLOT_W-1:0]    pos_slot_t;
    typedef logic [AUX_SLOT_W-1:0]    aux_slot_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_POSITION_MIN  = 3'd0,
        CFG_POSITION_MAX  = 3'd1,
        CFG_VELOCITY_MIN  = 3'd2,
        CFG_VELOCITY_MAX  = 3'd3,
        CFG_TORQUE_MIN    = 3'd4,
        CFG_TORQUE_MAX    = 3'd5,
        CFG_STIFFNESS_MAX = 3'd6,
        CFG_DAMPING_MAX   = 3'd7
    } cfg_index_t;

    localparam value_t POSITION_MIN_RST  = -32'sd823550;
    localparam value_t POSITION_MAX_RST  = 32'sd823550;
    localparam value_t VELOCITY_MIN_RST  = -32'sd2883584;
    localparam value_t VELOCITY_MAX_RST  = 32'sd2883584;
    localparam value_t TORQUE_MIN_RST    = -32'sd1114112;
    localparam value_t TORQUE_MAX_RST    = 32'sd1114112;
    localparam gain_t  STIFFNESS_MAX_RST = 31'd32768000;
    localparam gain_t  DAMPING_MAX_RST   = 31'd327680;

endpackage

// ===== rtl/core/impedance_command_frame_pack_top.sv =====
// Throughput: one transfer per cycle unless the output is blocked; each divider is a pipelined
// restoring divider with one quotient bit per stage.
// Reset: synchronous aresetn clears all valid bits and reloads the range registers with
// their defaults; datapath registers are not reset.
module impedance_command_frame_pack_top #(
    parameter int POS_CODE_BITS = 16,
    parameter int AUX_CODE_BITS = 12
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,

    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  icfp_pkg::value_t                      s_goal_position,
    input  icfp_pkg::value_t                      s_goal_velocity,
    input  icfp_pkg::value_t                      s_stiffness_gain,
    input  icfp_pkg::value_t                      s_damping_gain,
    input  icfp_pkg::value_t                      s_feed_torque,

    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [31:0]                           m_payload_high,
    output logic [31:0]                           m_payload_low,

    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [icfp_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [icfp_pkg::DATA_W-1:0]           cfg_data
);

    localparam int ITERS = (POS_CODE_BITS > AUX_CODE_BITS) ? POS_CODE_BITS : AUX_CODE_BITS;
    localparam int LAT   = 4 + ITERS;
    localparam int DW    = icfp_pkg::DATA_W;

    icfp_pkg::value_t     position_min_reg;
    icfp_pkg::value_t     position_max_reg;
    icfp_pkg::value_t     velocity_min_reg;
    icfp_pkg::value_t     velocity_max_reg;
    icfp_pkg::value_t     torque_min_reg;
    icfp_pkg::value_t     torque_max_reg;
    icfp_pkg::gain_t      stiffness_max_reg;
    icfp_pkg::gain_t      damping_max_reg;

    logic [LAT-1:0]       v_reg;
    logic                 out_take;
    logic                 en;
    logic                 m_valid_reg;
    logic [31:0]          payload_high_reg;
    logic [31:0]          payload_low_reg;

    icfp_pkg::value_t     tq_clamp;
    icfp_pkg::value_ext_t tq_neg_next;
    icfp_pkg::value_ext_t pos_reg;
    icfp_pkg::value_ext_t vel_reg;
    icfp_pkg::value_ext_t kp_reg;
    icfp_pkg::value_ext_t kd_reg;
    icfp_pkg::value_ext_t tq_reg;
    icfp_pkg::value_t     kp_hi;
    icfp_pkg::value_t     kd_hi;

    logic [POS_CODE_BITS-1:0] cp;
    logic [AUX_CODE_BITS-1:0] cv;
    logic [AUX_CODE_BITS-1:0] ck;
    logic [AUX_CODE_BITS-1:0] cd;
    logic [AUX_CODE_BITS-1:0] ct;
    logic [63:0]              payload_c;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            position_min_reg  <= icfp_pkg::POSITION_MIN_RST;
            position_max_reg  <= icfp_pkg::POSITION_MAX_RST;
            velocity_min_reg  <= icfp_pkg::VELOCITY_MIN_RST;
            velocity_max_reg  <= icfp_pkg::VELOCITY_MAX_RST;
            torque_min_reg    <= icfp_pkg::TORQUE_MIN_RST;
            torque_max_reg    <= icfp_pkg::TORQUE_MAX_RST;
            stiffness_max_reg <= icfp_pkg::STIFFNESS_MAX_RST;
            damping_max_reg   <= icfp_pkg::DAMPING_MAX_RST;
        end else if (cfg_valid) begin
            unique case (icfp_pkg::cfg_index_t'(cfg_index))
                icfp_pkg::CFG_POSITION_MIN:  position_min_reg  <= cfg_data;
                icfp_pkg::CFG_POSITION_MAX:  position_max_reg  <= cfg_data;
                icfp_pkg::CFG_VELOCITY_MIN:  velocity_min_reg  <= cfg_data;
                icfp_pkg::CFG_VELOCITY_MAX:  velocity_max_reg  <= cfg_data;
                icfp_pkg::CFG_TORQUE_MIN:    torque_min_reg    <= cfg_data;
                icfp_pkg::CFG_TORQUE_MAX:    torque_max_reg    <= cfg_data;
                icfp_pkg::CFG_STIFFNESS_MAX: stiffness_max_reg <= cfg_data[icfp_pkg::GAIN_W-1:0];
                icfp_pkg::CFG_DAMPING_MAX:   damping_max_reg   <= cfg_data[icfp_pkg::GAIN_W-1:0];
            endcase
        end
    end

    // pipeline advances unless the last stage is full and the output is blocked
    assign out_take = !m_valid_reg || m_ready;
    assign en       = out_take || !v_reg[LAT-1];
    assign s_ready  = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[LAT-2:0], s_valid};
        end
    end

    always_comb begin
        priority if (s_feed_torque > torque_max_reg) begin
            tq_clamp = torque_max_reg;
        end else if (s_feed_torque < torque_min_reg) begin
            tq_clamp = torque_min_reg;
        end else begin
            tq_clamp = s_feed_torque;
        end
    end

    assign tq_neg_next = -$signed({tq_clamp[DW-1], tq_clamp});

    always_ff @(posedge aclk) begin
        if (en) begin
            pos_reg <= {s_goal_position[DW-1], s_goal_position};
            vel_reg <= {s_goal_velocity[DW-1], s_goal_velocity};
            kp_reg  <= {s_stiffness_gain[DW-1], s_stiffness_gain};
            kd_reg  <= {s_damping_gain[DW-1], s_damping_gain};
            tq_reg  <= tq_neg_next;
        end
    end

    assign kp_hi = $signed({1'b0, stiffness_max_reg});
    assign kd_hi = $signed({1'b0, damping_max_reg});

    icfp_scale #(.CODE_BITS(POS_CODE_BITS), .ITERS(ITERS)) u_pos (
        .aclk(aclk), .en(en), .x_in(pos_reg),
        .lo(position_min_reg), .hi(position_max_reg), .code(cp)
    );

    icfp_scale #(.CODE_BITS(AUX_CODE_BITS), .ITERS(ITERS)) u_vel (
        .aclk(aclk), .en(en), .x_in(vel_reg),
        .lo(velocity_min_reg), .hi(velocity_max_reg), .code(cv)
    );

    icfp_scale #(.CODE_BITS(AUX_CODE_BITS), .ITERS(ITERS)) u_kp (
        .aclk(aclk), .en(en), .x_in(kp_reg),
        .lo('0), .hi(kp_hi), .code(ck)
    );

    icfp_scale #(.CODE_BITS(AUX_CODE_BITS), .ITERS(ITERS)) u_kd (
        .aclk(aclk), .en(en), .x_in(kd_reg),
        .lo('0), .hi(kd_hi), .code(cd)
    );

    icfp_scale #(.CODE_BITS(AUX_CODE_BITS), .ITERS(ITERS)) u_tq (
        .aclk(aclk), .en(en), .x_in(tq_reg),
        .lo(torque_min_reg), .hi(torque_max_reg), .code(ct)
    );

    assign payload_c = {icfp_pkg::pos_slot_t'(cp), icfp_pkg::aux_slot_t'(cv),
                        icfp_pkg::aux_slot_t'(ck), icfp_pkg::aux_slot_t'(cd),
                        icfp_pkg::aux_slot_t'(ct)};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_take) begin
            m_valid_reg <= v_reg[LAT-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (out_take) begin
            payload_high_reg <= payload_c[63:32];
            payload_low_reg  <= payload_c[31:0];
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_payload_high = payload_high_reg;
    assign m_payload_low  = payload_low_reg;

endmodule

// ===== rtl/core/icfp_scale.sv =====
module icfp_scale #(
    parameter int CODE_BITS = 12,
    parameter int ITERS     = 16
) (
    input  logic                          aclk,
    input  logic                          en,
    input  icfp_pkg::value_ext_t          x_in,
    input  icfp_pkg::value_t              lo,
    input  icfp_pkg::value_t              hi,
    output logic [CODE_BITS-1:0]          code
);

    localparam int DW = icfp_pkg::DATA_W;
    localparam int NW = DW + ITERS;

    icfp_pkg::value_ext_t lo_ext;
    icfp_pkg::value_ext_t hi_ext;
    icfp_pkg::value_ext_t span_c;
    icfp_pkg::value_t     xc_next;
    icfp_pkg::value_t     xc_reg;
    icfp_pkg::value_ext_t diff_c;
    logic [DW-1:0]        d_reg;
    logic [DW-1:0]        span_reg;
    logic                 span_pos_reg;
    logic [NW-1:0]        n_c;

    logic [DW-1:0]        r_reg    [0:ITERS-1];
    logic [ITERS-1:0]     nlow_reg [0:ITERS-1];
    logic [ITERS-1:0]     q_reg    [0:ITERS];

    logic [DW:0]          trial    [0:ITERS-1];
    logic                 ge       [0:ITERS-1];
    logic [DW-1:0]        r_next   [0:ITERS-1];

    assign lo_ext = {lo[DW-1], lo};
    assign hi_ext = {hi[DW-1], hi};
    assign span_c = hi_ext - lo_ext;

    always_comb begin
        priority if (x_in > hi_ext) begin
            xc_next = hi;
        end else if (x_in < lo_ext) begin
            xc_next = lo;
        end else begin
            xc_next = x_in[DW-1:0];
        end
    end

    assign diff_c = {xc_reg[DW-1], xc_reg} - lo_ext;
    assign n_c    = (NW'(d_reg) << CODE_BITS) - NW'(d_reg);

    // the user must change ranges only while idle; the block itself does not enforce this
    always_ff @(posedge aclk) begin
        span_reg     <= span_c[DW-1:0];
        span_pos_reg <= !span_c[DW] && (span_c != '0);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            xc_reg <= xc_next;
            d_reg  <= diff_c[DW-1:0];
        end
    end

    // restoring divide, one quotient bit per stage
    always_comb begin
        for (int k = 0; k < ITERS; k++) begin
            trial[k] = {r_reg[k], nlow_reg[k][ITERS-1]};
            ge[k]    = trial[k] >= {1'b0, span_reg};
            if (ge[k]) begin
                r_next[k] = DW'(trial[k] - {1'b0, span_reg});
            end else begin
                r_next[k] = trial[k][DW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg[0]    <= n_c[NW-1:ITERS];
            nlow_reg[0] <= n_c[ITERS-1:0];
            q_reg[0]    <= '0;
            for (int k = 0; k < ITERS - 1; k++) begin
                r_reg[k+1]    <= r_next[k];
                nlow_reg[k+1] <= nlow_reg[k] << 1;
            end
            for (int k = 0; k < ITERS; k++) begin
                q_reg[k+1] <= {q_reg[k][ITERS-2:0], ge[k]};
            end
        end
    end

    assign code = span_pos_reg ? q_reg[ITERS][CODE_BITS-1:0] : '0;

endmodule

// ===== rtl/core/icfp_checker.sv =====
module icfp_checker (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_ready,
    input  logic                                  m_valid,
    input  logic                                  m_ready,
    input  logic [31:0]                           m_payload_high,
    input  logic [31:0]                           m_payload_low
);

    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("m_valid not cleared by reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_payload_high) && $stable(m_payload_low))
        else $error("stalled result changed");

    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input stalled while output drains");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

endmodule

bind impedance_command_frame_pack_top icfp_checker u_icfp_checker (.*);

// ===== tb/sv/tb_impedance_command_frame_pack_top.sv =====
module tb_impedance_command_frame_pack_top;
    timeunit 1ns;
    timeprecision 1ps;

    import icfp_pkg::*;

    localparam int POS_BITS         = 16;
    localparam int AUX_BITS         = 12;
    localparam int PIPE_LATENCY     = ((POS_BITS > AUX_BITS) ? POS_BITS : AUX_BITS) + 4;
    localparam int N_DIRECTED       = 16;
    localparam int N_PHASES         = 12;
    localparam int PHASE_ITEMS      = 78;
    localparam int HOLD_PHASE       = 5;
    localparam int SINK_HOLD_CYCLES = 400;
    localparam int MAX_REPORTS      = 10;

    localparam value_t MIN32 = 32'sh8000_0000;
    localparam value_t MAX32 = 32'sh7FFF_FFFF;

    typedef struct {
        value_t pos;
        value_t vel;
        value_t kp;
        value_t kd;
        value_t trq;
    } cmd_t;

    typedef struct {
        cmd_t        c;
        bit          typed;
        logic [63:0] frame;
    } vec_t;

    typedef logic [DATA_W-1:0] cfg_set_t [8];

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    value_t                 s_goal_position;
    value_t                 s_goal_velocity;
    value_t                 s_stiffness_gain;
    value_t                 s_damping_gain;
    value_t                 s_feed_torque;
    logic                   m_valid;
    logic                   m_ready;
    logic [31:0]            m_payload_high;
    logic [31:0]            m_payload_low;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [DATA_W-1:0]      cfg_data;

    longint pos_lo = longint'(POSITION_MIN_RST);
    longint pos_hi = longint'(POSITION_MAX_RST);
    longint vel_lo = longint'(VELOCITY_MIN_RST);
    longint vel_hi = longint'(VELOCITY_MAX_RST);
    longint trq_lo = longint'(TORQUE_MIN_RST);
    longint trq_hi = longint'(TORQUE_MAX_RST);
    longint kp_hi  = longint'(STIFFNESS_MAX_RST);
    longint kd_hi  = longint'(DAMPING_MAX_RST);

    logic [63:0] pending_frames [$];
    int          fail_count = 0;
    int          src_burst = 0;
    bit          sink_hold = 1'b0;

    vec_t directed_vecs [N_DIRECTED] = '{
        '{'{MIN32, MIN32, MIN32, MIN32, MIN32}, 1'b1, 64'h0000_0000_0000_0FFF},
        '{'{MAX32, MAX32, MAX32, MAX32, MAX32}, 1'b1, 64'hFFFF_FFFF_FFFF_F000},
        '{'{32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0}, 1'b1, 64'h7FFF_7FF0_0000_07FF},
        '{'{POSITION_MIN_RST, VELOCITY_MIN_RST, 32'sd0, 32'sd0, TORQUE_MIN_RST},
          1'b1, 64'h0000_0000_0000_0FFF},
        '{'{POSITION_MAX_RST, VELOCITY_MAX_RST, value_t'(STIFFNESS_MAX_RST),
            value_t'(DAMPING_MAX_RST), TORQUE_MAX_RST},
          1'b1, 64'hFFFF_FFFF_FFFF_F000},
        '{'{value_t'(POSITION_MIN_RST + 1), value_t'(VELOCITY_MIN_RST + 1), 32'sd1, 32'sd1,
            value_t'(TORQUE_MIN_RST + 1)}, 1'b0, 64'h0},
        '{'{value_t'(POSITION_MAX_RST - 1), value_t'(VELOCITY_MAX_RST - 1),
            value_t'(STIFFNESS_MAX_RST) - 1, value_t'(DAMPING_MAX_RST) - 1,
            value_t'(TORQUE_MAX_RST - 1)}, 1'b0, 64'h0},
        '{'{value_t'(POSITION_MIN_RST - 1), value_t'(VELOCITY_MIN_RST - 1), -32'sd1, -32'sd1,
            value_t'(TORQUE_MIN_RST - 1)}, 1'b0, 64'h0},
        '{'{value_t'(POSITION_MAX_RST + 1), value_t'(VELOCITY_MAX_RST + 1),
            value_t'(STIFFNESS_MAX_RST) + 1, value_t'(DAMPING_MAX_RST) + 1,
            value_t'(TORQUE_MAX_RST + 1)}, 1'b0, 64'h0},
        '{'{-32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1}, 1'b0, 64'h0},
        '{'{POSITION_MAX_RST, VELOCITY_MIN_RST, 32'sd16384000, 32'sd1, -32'sd1}, 1'b0, 64'h0},
        '{'{32'shAAAA_AAAA, 32'shAAAA_AAAA, 32'shAAAA_AAAA, 32'shAAAA_AAAA, 32'shAAAA_AAAA},
          1'b0, 64'h0},
        '{'{32'sh5555_5555, 32'sh5555_5555, 32'sh5555_5555, 32'sh5555_5555, 32'sh5555_5555},
          1'b0, 64'h0},
        '{'{32'sd0, 32'sd0, 32'sd0, 32'sd0, TORQUE_MAX_RST}, 1'b0, 64'h0},
        '{'{32'sd1, 32'sd1, 32'sd0, 32'sd0, 32'sd1}, 1'b0, 64'h0},
        '{'{32'sd65536, -32'sd65536, 32'sd32768, 32'sd163840, 32'sd557056}, 1'b0, 64'h0}
    };

    impedance_command_frame_pack_top #(
        .POS_CODE_BITS(POS_BITS),
        .AUX_CODE_BITS(AUX_BITS)
    ) DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_goal_position  (s_goal_position),
        .s_goal_velocity  (s_goal_velocity),
        .s_stiffness_gain (s_stiffness_gain),
        .s_damping_gain   (s_damping_gain),
        .s_feed_torque    (s_feed_torque),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_payload_high   (m_payload_high),
        .m_payload_low    (m_payload_low),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic longint clamp_q(longint x, longint lo, longint hi);
        if (x > hi) return hi;
        if (x < lo) return lo;
        return x;
    endfunction

    function automatic longint range_code(longint x, longint lo, longint hi, int bits);
        longint mask;
        longint span;
        mask = (longint'(1) << bits) - 1;
        span = hi - lo;
        if (span <= 0) return 0;
        return ((clamp_q(x, lo, hi) - lo) * mask / span) & mask;
    endfunction

    function automatic logic [63:0] expected_frame(cmd_t c);
        longint              neg_trq;
        logic [POS_BITS-1:0] cp;
        logic [AUX_BITS-1:0] cv;
        logic [AUX_BITS-1:0] ck;
        logic [AUX_BITS-1:0] cd;
        logic [AUX_BITS-1:0] ct;
        neg_trq = -clamp_q(longint'(c.trq), trq_lo, trq_hi);
        cp = POS_BITS'(range_code(longint'(c.pos), pos_lo, pos_hi, POS_BITS));
        cv = AUX_BITS'(range_code(longint'(c.vel), vel_lo, vel_hi, AUX_BITS));
        ck = AUX_BITS'(range_code(longint'(c.kp), 64'sd0, kp_hi, AUX_BITS));
        cd = AUX_BITS'(range_code(longint'(c.kd), 64'sd0, kd_hi, AUX_BITS));
        ct = AUX_BITS'(range_code(neg_trq, trq_lo, trq_hi, AUX_BITS));
        return {cp, cv, ck, cd, ct};
    endfunction

    function automatic value_t pick_value(longint lo, longint hi);
        longint          v;
        longint unsigned r;
        longint unsigned width;
        int              sel;
        sel = $urandom_range(0, 99);
        r = {$urandom, $urandom};
        if (sel < 20) begin
            case ($urandom_range(0, 5))
                0: v = lo;
                1: v = hi;
                2: v = lo - 1;
                3: v = hi + 1;
                4: v = lo + 1;
                default: v = hi - 1;
            endcase
        end else if (sel < 45 || hi < lo) begin
            v = r;
        end else begin
            width = hi - lo + 1;
            v = lo + (r % width);
        end
        return v[DATA_W-1:0];
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_cmd(cmd_t c, bit typed, logic [63:0] typed_frame);
        s_valid          <= 1'b1;
        s_goal_position  <= c.pos;
        s_goal_velocity  <= c.vel;
        s_stiffness_gain <= c.kp;
        s_damping_gain   <= c.kd;
        s_feed_torque    <= c.trq;
        do @(posedge aclk); while (!s_ready);
        pending_frames.push_back(typed ? typed_frame : expected_frame(c));
    endtask

    task automatic source_idle();
        int gap;
        gap = 0;
        if (src_burst > 0) begin
            src_burst--;
        end else if ($urandom_range(0, 99) < 3) begin
            src_burst = $urandom_range(30, 120);
        end else if ($urandom_range(0, 99) < 35) begin
            gap = idle_len();
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_frames.size() != 0) @(posedge aclk);
        repeat (PIPE_LATENCY) @(posedge aclk);
    endtask

    initial begin
        cmd_t        cmd;
        cfg_set_t    v;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] t;
        int          sel;

        aresetn          <= 1'b0;
        s_valid          <= 1'b0;
        s_goal_position  <= '0;
        s_goal_velocity  <= '0;
        s_stiffness_gain <= '0;
        s_damping_gain   <= '0;
        s_feed_torque    <= '0;
        cfg_valid        <= 1'b0;
        cfg_index        <= '0;
        cfg_data         <= '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < N_DIRECTED; i++) begin
            send_cmd(directed_vecs[i].c, directed_vecs[i].typed, directed_vecs[i].frame);
            source_idle();
        end

        for (int p = 0; p < N_PHASES; p++) begin
            wait_idle();
            case (p)
                0: v = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                         32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
                // inverted, equal and zero spans
                1: v = '{32'h0001_0000, 32'hFFFF_0000, 32'h0002_0000, 32'h0002_0000,
                         32'h0000_1000, 32'h8000_0000, 32'h8000_0000, 32'h0000_0000};
                2: v = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0000,
                         32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001, 32'h0000_0001};
                // lopsided torque range, negation clamps again
                3: v = '{POSITION_MIN_RST, POSITION_MAX_RST, VELOCITY_MIN_RST, VELOCITY_MAX_RST,
                         32'hFFFE_7960, 32'h0000_7530, 32'h7FFF_FFFF, 32'h0000_0001};
                4: v = '{POSITION_MIN_RST, POSITION_MAX_RST, VELOCITY_MIN_RST, VELOCITY_MAX_RST,
                         TORQUE_MIN_RST, TORQUE_MAX_RST, DATA_W'(STIFFNESS_MAX_RST),
                         DATA_W'(DAMPING_MAX_RST)};
                default: begin
                    for (int i = 0; i < 6; i += 2) begin
                        a = $urandom;
                        b = $urandom;
                        sel = $urandom_range(0, 9);
                        if (sel < 6) begin
                            if (value_t'(a) > value_t'(b)) begin
                                t = a;
                                a = b;
                                b = t;
                            end
                        end else if (sel < 8) begin
                            b = a + $urandom_range(1, 4096);
                        end
                        v[i]   = a;
                        v[i+1] = b;
                    end
                    for (int i = 6; i < 8; i++) begin
                        v[i] = $urandom;
                        if ($urandom_range(0, 1) == 1) begin
                            v[i][GAIN_W-1:0] = v[i][GAIN_W-1:0] >> $urandom_range(4, 28);
                        end
                    end
                end
            endcase

            for (int i = 0; i < 8; i++) begin
                cfg_valid <= 1'b1;
                cfg_index <= cfg_index_t'(i);
                cfg_data  <= v[i];
                do @(posedge aclk); while (!cfg_ready);
                case (cfg_index_t'(i))
                    CFG_POSITION_MIN:  pos_lo = longint'(value_t'(v[i]));
                    CFG_POSITION_MAX:  pos_hi = longint'(value_t'(v[i]));
                    CFG_VELOCITY_MIN:  vel_lo = longint'(value_t'(v[i]));
                    CFG_VELOCITY_MAX:  vel_hi = longint'(value_t'(v[i]));
                    CFG_TORQUE_MIN:    trq_lo = longint'(value_t'(v[i]));
                    CFG_TORQUE_MAX:    trq_hi = longint'(value_t'(v[i]));
                    CFG_STIFFNESS_MAX: kp_hi  = longint'(v[i][GAIN_W-1:0]);
                    CFG_DAMPING_MAX:   kd_hi  = longint'(v[i][GAIN_W-1:0]);
                endcase
            end
            cfg_valid <= 1'b0;

            if (p == HOLD_PHASE) sink_hold = 1'b1;

            for (int k = 0; k < PHASE_ITEMS; k++) begin
                cmd.pos = pick_value(pos_lo, pos_hi);
                cmd.vel = pick_value(vel_lo, vel_hi);
                cmd.kp  = pick_value(64'sd0, kp_hi);
                cmd.kd  = pick_value(64'sd0, kd_hi);
                cmd.trq = pick_value(trq_lo, trq_hi);
                send_cmd(cmd, 1'b0, '0);
                source_idle();
            end
        end

        wait_idle();
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        int stall_left;
        int burst_left;
        int r;
        stall_left = 0;
        burst_left = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (sink_hold) begin
                m_ready <= 1'b0;
                repeat (SINK_HOLD_CYCLES) @(posedge aclk);
                sink_hold = 1'b0;
                m_ready <= 1'b1;
            end else if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else if (burst_left > 0) begin
                m_ready <= 1'b1;
                burst_left--;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 25) begin
                    m_ready <= 1'b0;
                    stall_left = idle_len() - 1;
                end else begin
                    m_ready <= 1'b1;
                    if (r < 28) burst_left = $urandom_range(30, 120);
                end
            end
        end
    end

    always @(posedge aclk) begin
        logic [63:0] want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_frames.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS) begin
                    $display("%0t: result transfer with none pending: high=%h low=%h",
                             $realtime, m_payload_high, m_payload_low);
                end
            end else begin
                want = pending_frames.pop_front();
                if (m_payload_high !== want[63:32] || m_payload_low !== want[31:0]) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $display("%0t: payload_high exp %h got %h, payload_low exp %h got %h",
                                 $realtime, want[63:32], m_payload_high,
                                 want[31:0], m_payload_low);
                    end
                end
            end
        end
    end

    initial begin
        #20ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
